/* src/amfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amfs_pkg
// Shared types, constants and the microprogram ROM of the AT modem frame
// sender.
// ----------------------------------------------------------------------------
package amfs_pkg;

  // Sizing
  localparam int unsigned MaxPayload     = 12;
  localparam int unsigned ReplyLineBytes = 32;
  localparam int unsigned LineMax        = ReplyLineBytes - 1;
  localparam int unsigned IdxW           = $clog2(MaxPayload);
  localparam int unsigned CntW           = $clog2(MaxPayload + 1);
  localparam int unsigned PosW           = $clog2(ReplyLineBytes);
  localparam int unsigned HeadLen        = 6;

  // Input operations
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpRxChar  = 2'd1;
  localparam logic [1:0] OpPayload = 2'd2;

  // Event codes
  localparam logic [2:0] EvNone      = 3'd0;
  localparam logic [2:0] EvReady     = 3'd1;
  localparam logic [2:0] EvError     = 3'd2;
  localparam logic [2:0] EvSendStart = 3'd3;
  localparam logic [2:0] EvSendDone  = 3'd4;
  localparam logic [2:0] EvReject    = 3'd5;

  // Controller modes
  localparam logic [2:0] ModeStartup    = 3'd0;
  localparam logic [2:0] ModeResetLow   = 3'd1;
  localparam logic [2:0] ModeBootWait   = 3'd2;
  localparam logic [2:0] ModeProbeReply = 3'd3;
  localparam logic [2:0] ModeReady      = 3'd4;
  localparam logic [2:0] ModeSendReply  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] RegStartupDelay  = 3'd0;
  localparam logic [2:0] RegResetLowTime  = 3'd1;
  localparam logic [2:0] RegBootWait      = 3'd2;
  localparam logic [2:0] RegProbeReplyWt  = 3'd3;
  localparam logic [2:0] RegSendReplyWt   = 3'd4;

  // Characters
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChA  = 8'h41;
  localparam logic [7:0] ChT  = 8'h54;
  localparam logic [7:0] ChO  = 8'h4F;
  localparam logic [7:0] ChK  = 8'h4B;

  // Microprogram
  localparam int unsigned PcW = 5;

  localparam logic [PcW-1:0] AEv0    = 5'd0;
  localparam logic [PcW-1:0] AFail   = 5'd1;
  localparam logic [PcW-1:0] AReject = 5'd2;
  localparam logic [PcW-1:0] AReady  = 5'd3;
  localparam logic [PcW-1:0] ADone   = 5'd4;
  localparam logic [PcW-1:0] AProbe  = 5'd6;
  localparam logic [PcW-1:0] ASend   = 5'd10;
  localparam logic [PcW-1:0] AHexHi  = 5'd16;
  localparam logic [PcW-1:0] ACheck  = 5'd19;

  typedef enum logic [1:0] {
    CSEL_CONST,
    CSEL_HEX_HI,
    CSEL_HEX_LO
  } csel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_END,
    JMP_LOOP,
    JMP_CHECK
  } jmp_e;

  typedef struct packed {
    logic       emit;
    csel_e      csel;
    logic [7:0] chr;
    logic [2:0] evt;
    logic       last;
    jmp_e       jmp;
  } ctrl_t;

  function automatic ctrl_t cw(logic emit, csel_e csel, logic [7:0] chr,
                               logic [2:0] evt, logic last, jmp_e jmp);
    ctrl_t w;
    w.emit = emit;
    w.csel = csel;
    w.chr  = chr;
    w.evt  = evt;
    w.last = last;
    w.jmp  = jmp;
    return w;
  endfunction

  function automatic logic [7:0] cmd_head(logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0:    c = 8'h41; // A
      3'd1:    c = 8'h54; // T
      3'd2:    c = 8'h24; // $
      3'd3:    c = 8'h53; // S
      3'd4:    c = 8'h46; // F
      default: c = 8'h3D; // =
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  // Control store: one word per step
  function automatic ctrl_t rom_word(logic [PcW-1:0] pc);
    ctrl_t w;
    unique case (pc)
      5'd0:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvNone,      1'b1, JMP_END);
      5'd1:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvError,     1'b1, JMP_END);
      5'd2:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvReject,    1'b1, JMP_END);
      5'd3:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvReady,     1'b1, JMP_END);
      5'd4:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvSendDone,  1'b0, JMP_NEXT);
      5'd5:    w = cw(1'b1, CSEL_CONST,  8'h00,       EvReady,     1'b1, JMP_END);
      5'd6:    w = cw(1'b1, CSEL_CONST,  ChCr,        EvNone,      1'b0, JMP_NEXT);
      5'd7:    w = cw(1'b1, CSEL_CONST,  ChA,         EvNone,      1'b0, JMP_NEXT);
      5'd8:    w = cw(1'b1, CSEL_CONST,  ChT,         EvNone,      1'b0, JMP_NEXT);
      5'd9:    w = cw(1'b1, CSEL_CONST,  ChCr,        EvNone,      1'b1, JMP_END);
      5'd10:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd0), EvNone,   1'b0, JMP_NEXT);
      5'd11:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd1), EvNone,   1'b0, JMP_NEXT);
      5'd12:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd2), EvNone,   1'b0, JMP_NEXT);
      5'd13:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd3), EvNone,   1'b0, JMP_NEXT);
      5'd14:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd4), EvNone,   1'b0, JMP_NEXT);
      5'd15:   w = cw(1'b1, CSEL_CONST,  cmd_head(3'd5), EvNone,   1'b0, JMP_NEXT);
      5'd16:   w = cw(1'b1, CSEL_HEX_HI, 8'h00,       EvNone,      1'b0, JMP_NEXT);
      5'd17:   w = cw(1'b1, CSEL_HEX_LO, 8'h00,       EvNone,      1'b0, JMP_LOOP);
      5'd18:   w = cw(1'b1, CSEL_CONST,  ChCr,        EvSendStart, 1'b1, JMP_END);
      5'd19:   w = cw(1'b0, CSEL_CONST,  8'h00,       EvNone,      1'b0, JMP_CHECK);
      default: w = cw(1'b0, CSEL_CONST,  8'h00,       EvNone,      1'b0, JMP_END);
    endcase
    return w;
  endfunction

endpackage

/* src/at_modem_frame_sender.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_modem_frame_sender
// Brings up an AT-command radio modem and sends payload frames through it,
// checking echo and OK reply lines.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid_i / in_ready_o | op_i, data_i, frame_end_i
//  output   | out_valid_o/out_ready_i | tx_valid_o, tx_char_o, reset_level_o,
//           |                         | event_res_o, is_ready_o, last_o
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied 1)
//
// Timing: an input beat is decoded in the cycle it is accepted. Ticks and
// payload bytes that give no result finish in that same cycle. A received
// character takes an extra control step (payload store read) before any
// result. Results come from microcode steps, so the closing byte of a frame
// steps through the command head, two hex digits per byte and a closing CR;
// output stalls hold the sequencer in place.
// in_ready_o is high whenever the sequencer is idle; the output register
// lets the next input beat in while the final result still waits.
// Reset: config and control state reset, but not chr_q or output data bits.
// ----------------------------------------------------------------------------
module at_modem_frame_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_i,
  input  logic        frame_end_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_char_o,
  output logic        reset_level_o,
  output logic [2:0]  event_res_o,
  output logic        is_ready_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = amfs_pkg::IdxW;
  localparam int unsigned CntW = amfs_pkg::CntW;
  localparam int unsigned PosW = amfs_pkg::PosW;
  localparam int unsigned PcW  = amfs_pkg::PcW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] startup_delay_q, reset_low_time_q, boot_wait_q;
  logic [15:0] probe_wait_q, send_wait_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_delay_q  <= 16'd100;
      reset_low_time_q <= 16'd100;
      boot_wait_q      <= 16'd3000;
      probe_wait_q     <= 16'd100;
      send_wait_q      <= 16'd8000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        amfs_pkg::RegStartupDelay: startup_delay_q  <= pwdata[15:0];
        amfs_pkg::RegResetLowTime: reset_low_time_q <= pwdata[15:0];
        amfs_pkg::RegBootWait:     boot_wait_q      <= pwdata[15:0];
        amfs_pkg::RegProbeReplyWt: probe_wait_q     <= pwdata[15:0];
        amfs_pkg::RegSendReplyWt:  send_wait_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      amfs_pkg::RegStartupDelay: prdata = {16'd0, startup_delay_q};
      amfs_pkg::RegResetLowTime: prdata = {16'd0, reset_low_time_q};
      amfs_pkg::RegBootWait:     prdata = {16'd0, boot_wait_q};
      amfs_pkg::RegProbeReplyWt: prdata = {16'd0, probe_wait_q};
      amfs_pkg::RegSendReplyWt:  prdata = {16'd0, send_wait_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [2:0]      mode_q, mode_d;
  logic [15:0]     delay_q, delay_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            line_q, line_d;         // 0: echo line, 1: OK line
  logic [PosW-1:0] pos_q, pos_d;
  logic            mis_q, mis_d;
  logic            pin_q, pin_d;

  // sequencer
  logic            busy_q, busy_d;
  logic [PcW-1:0]  pc_q, pc_d;
  logic [IdxW-1:0] bidx_q, bidx_d;
  logic [7:0]      chr_q, chr_d;

  // output register
  logic            ovalid_q, ovalid_d;
  logic            otx_q, otx_d;
  logic [7:0]      ochar_q, ochar_d;
  logic            olvl_q, olvl_d;
  logic [2:0]      oev_q, oev_d;
  logic            ordy_q, ordy_d;
  logic            olast_q, olast_d;

  // payload store
  logic            ram_we;
  logic [7:0]      ram_rdata;

  amfs_ram #(
    .Width (8),
    .Depth (amfs_pkg::MaxPayload)
  ) u_payload (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (data_i),
    .raddr_i (bidx_d),
    .rdata_o (ram_rdata)
  );

  amfs_pkg::ctrl_t ctrl;
  logic            can_load, step_go, accept;
  logic [7:0]      emit_char;

  // reply-line helpers
  logic [PosW-1:0] body_len, pos_off;
  logic [PosW:0]   pos_inc;
  logic            exp_ok;
  logic [7:0]      exp_char;
  logic [15:0]     delay_dec;
  logic            stored;
  logic [CntW-1:0] count_new;
  logic            ovf_new;

  assign ctrl     = amfs_pkg::rom_word(pc_q);
  assign can_load = !ovalid_q || out_ready_i;
  assign step_go  = busy_q && (!ctrl.emit || can_load);
  assign accept   = in_valid_i && !busy_q;
  assign in_ready_o = !busy_q;

  always_comb begin
    unique case (ctrl.csel)
      amfs_pkg::CSEL_HEX_HI: emit_char = amfs_pkg::hex_digit(ram_rdata[7:4]);
      amfs_pkg::CSEL_HEX_LO: emit_char = amfs_pkg::hex_digit(ram_rdata[3:0]);
      default:               emit_char = ctrl.chr;
    endcase
  end

  // Expected reply character at the current line position
  assign body_len = (line_q || mode_q != amfs_pkg::ModeSendReply) ? PosW'(2)
                  : PosW'(amfs_pkg::HeadLen) + PosW'({count_q, 1'b0});
  assign pos_off  = pos_q - PosW'(amfs_pkg::HeadLen);
  assign pos_inc  = {1'b0, pos_q} + 1'b1;

  always_comb begin
    exp_ok = pos_q < body_len;
    if (line_q) begin
      exp_char = (pos_q == '0) ? amfs_pkg::ChO : amfs_pkg::ChK;
    end else if (mode_q != amfs_pkg::ModeSendReply) begin
      exp_char = (pos_q == '0) ? amfs_pkg::ChA : amfs_pkg::ChT;
    end else if (pos_q < PosW'(amfs_pkg::HeadLen)) begin
      exp_char = amfs_pkg::cmd_head(pos_q[2:0]);
    end else begin
      exp_char = pos_off[0] ? amfs_pkg::hex_digit(ram_rdata[3:0])
                            : amfs_pkg::hex_digit(ram_rdata[7:4]);
    end
  end

  assign delay_dec = (delay_q != 16'd0) ? (delay_q - 16'd1) : 16'd0;
  assign stored    = (mode_q == amfs_pkg::ModeReady) &&
                     (count_q < CntW'(amfs_pkg::MaxPayload));
  assign count_new = stored ? (count_q + 1'b1) : count_q;
  assign ovf_new   = ovf_q | ~stored;
  assign ram_we    = accept && (op_i == amfs_pkg::OpPayload) && stored;

  always_comb begin
    mode_d  = mode_q;
    delay_d = delay_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    line_d  = line_q;
    pos_d   = pos_q;
    mis_d   = mis_q;
    pin_d   = pin_q;
    busy_d  = busy_q;
    pc_d    = pc_q;
    bidx_d  = bidx_q;
    chr_d   = chr_q;

    if (busy_q) begin
      if (step_go) begin
        unique case (ctrl.jmp)
          amfs_pkg::JMP_NEXT: pc_d = pc_q + PcW'(1);
          amfs_pkg::JMP_END:  busy_d = 1'b0;
          amfs_pkg::JMP_LOOP: begin
            bidx_d = bidx_q + 1'b1;
            if (({1'b0, bidx_q} + 1'b1) < (IdxW+1)'(count_q)) begin
              pc_d = amfs_pkg::AHexHi;
            end else begin
              pc_d = pc_q + PcW'(1);
            end
          end
          default: begin
            // reply character check
            busy_d = 1'b0;
            if (chr_q == amfs_pkg::ChCr) begin
              if (pos_q != '0) begin
                if (mis_q || pos_q != body_len) begin
                  pin_d   = 1'b0;
                  mode_d  = amfs_pkg::ModeResetLow;
                  delay_d = reset_low_time_q;
                  busy_d  = 1'b1;
                  pc_d    = amfs_pkg::AFail;
                end else begin
                  pos_d = '0;
                  mis_d = 1'b0;
                  if (!line_q) begin
                    line_d = 1'b1;
                  end else begin
                    busy_d  = 1'b1;
                    pc_d    = (mode_q == amfs_pkg::ModeSendReply) ? amfs_pkg::ADone
                                                                   : amfs_pkg::AReady;
                    mode_d  = amfs_pkg::ModeReady;
                    count_d = '0;
                  end
                end
              end
            end else begin
              if (!exp_ok || exp_char != chr_q) begin
                mis_d = 1'b1;
              end
              pos_d = pos_inc[PosW-1:0];
              if (pos_inc >= (PosW+1)'(amfs_pkg::LineMax)) begin
                pin_d   = 1'b0;
                mode_d  = amfs_pkg::ModeResetLow;
                delay_d = reset_low_time_q;
                busy_d  = 1'b1;
                pc_d    = amfs_pkg::AFail;
              end
            end
          end
        endcase
      end
    end else if (in_valid_i) begin
      unique case (op_i)
        amfs_pkg::OpTick: begin
          if (mode_q != amfs_pkg::ModeReady) begin
            delay_d = delay_dec;
            if (delay_dec == 16'd0) begin
              busy_d = 1'b1;
              unique case (mode_q)
                amfs_pkg::ModeStartup: begin
                  pin_d   = 1'b0;
                  mode_d  = amfs_pkg::ModeResetLow;
                  delay_d = reset_low_time_q;
                  pc_d    = amfs_pkg::AEv0;
                end
                amfs_pkg::ModeResetLow: begin
                  pin_d   = 1'b1;
                  mode_d  = amfs_pkg::ModeBootWait;
                  delay_d = boot_wait_q;
                  pc_d    = amfs_pkg::AEv0;
                end
                amfs_pkg::ModeBootWait: begin
                  mode_d  = amfs_pkg::ModeProbeReply;
                  delay_d = probe_wait_q;
                  line_d  = 1'b0;
                  pos_d   = '0;
                  mis_d   = 1'b0;
                  pc_d    = amfs_pkg::AProbe;
                end
                default: begin
                  // reply window expired
                  pin_d   = 1'b0;
                  mode_d  = amfs_pkg::ModeResetLow;
                  delay_d = reset_low_time_q;
                  pc_d    = amfs_pkg::AFail;
                end
              endcase
            end
          end
        end
        amfs_pkg::OpRxChar: begin
          if ((mode_q == amfs_pkg::ModeProbeReply || mode_q == amfs_pkg::ModeSendReply)
              && data_i != amfs_pkg::ChLf) begin
            busy_d = 1'b1;
            pc_d   = amfs_pkg::ACheck;
            chr_d  = data_i;
            bidx_d = IdxW'(pos_off >> 1);
          end
        end
        amfs_pkg::OpPayload: begin
          count_d = count_new;
          ovf_d   = ovf_new;
          if (frame_end_i) begin
            busy_d = 1'b1;
            if (ovf_new || mode_q != amfs_pkg::ModeReady || count_new == '0) begin
              ovf_d   = 1'b0;
              count_d = '0;
              pc_d    = amfs_pkg::AReject;
            end else begin
              pc_d    = amfs_pkg::ASend;
              bidx_d  = '0;
              mode_d  = amfs_pkg::ModeSendReply;
              delay_d = send_wait_q;
              line_d  = 1'b0;
              pos_d   = '0;
              mis_d   = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: reset level and ready flag come from the settled state
  always_comb begin
    ovalid_d = ovalid_q;
    otx_d    = otx_q;
    ochar_d  = ochar_q;
    olvl_d   = olvl_q;
    oev_d    = oev_q;
    ordy_d   = ordy_q;
    olast_d  = olast_q;
    if (step_go && ctrl.emit) begin
      ovalid_d = 1'b1;
      otx_d    = (ctrl.csel != amfs_pkg::CSEL_CONST) || (ctrl.chr != 8'h00);
      ochar_d  = emit_char;
      olvl_d   = pin_q;
      oev_d    = ctrl.evt;
      ordy_d   = (mode_q == amfs_pkg::ModeReady);
      olast_d  = ctrl.last;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= amfs_pkg::ModeStartup;
      delay_q  <= 16'd100;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      line_q   <= 1'b0;
      pos_q    <= '0;
      mis_q    <= 1'b0;
      pin_q    <= 1'b1;
      busy_q   <= 1'b0;
      pc_q     <= '0;
      bidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      delay_q  <= delay_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      mis_q    <= mis_d;
      pin_q    <= pin_d;
      busy_q   <= busy_d;
      pc_q     <= pc_d;
      bidx_q   <= bidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q   <= chr_d;
    otx_q   <= otx_d;
    ochar_q <= ochar_d;
    olvl_q  <= olvl_d;
    oev_q   <= oev_d;
    ordy_q  <= ordy_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign tx_valid_o    = otx_q;
  assign tx_char_o     = ochar_q;
  assign reset_level_o = olvl_q;
  assign event_res_o   = oev_q;
  assign is_ready_o    = ordy_q;
  assign last_o        = olast_q;

endmodule

/* src/amfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
